[design/rag_deadlock_detector_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the deadlock detector
// Each macro checks one implication on the rising edge of clk, with the
// check held off while arst_n is low. Synthesis builds see empty macros.
// ----------------------------------------------------------------------------
`ifndef RAG_DEADLOCK_DETECTOR_CORE_ASSERT_SVH
`define RAG_DEADLOCK_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define RAG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define RAG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define RAG_ASSERT_NOW(label, ante, cons)
`define RAG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/rag_pkg.sv]
// ----------------------------------------------------------------------------
// rag_pkg
// Shared types and constants of the resource allocation graph deadlock
// detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rag_pkg;

	localparam int PROC_COUNT_DEF = 8;
	localparam int LOCK_COUNT_DEF = 8;
	localparam int ID_W           = 3;
	localparam int OUT_MAX        = 16;

	typedef enum logic [1:0] {
		ACT_REQUEST = 2'd0,
		ACT_ALLOC   = 2'd1,
		ACT_DEALLOC = 2'd2,
		ACT_DETECT  = 2'd3
	} rag_action_t;

	// Edge update command handed from the sequencer to the edge store.
	typedef struct packed {
		logic              valid;
		rag_action_t       action;
		logic [ID_W-1:0]   proc_id;
		logic [ID_W-1:0]   lock_id;
	} rag_upd_t;

endpackage

[design/rag_deadlock_detector_core.sv]
// ----------------------------------------------------------------------------
// rag_deadlock_detector_core
// Resource allocation graph with request, allocate and deallocate updates and
// a cycle search that reports the nodes of the first cycle found.
//
// Channel  Dir  Beat contents
// s_axis   in   tdata: action, proc_id, lock_id
// m_axis   out  tdata: node_id, victim_pid, victim_lock; tuser: found,
//               node_is_lock; tlast: last
//
// An edge update is written into the edge store when its beat is accepted.
// A detection tests one edge per cycle with a single stack engine: the
// depth-first search and the path search both backtrack, a process victim
// adds a scan over every lock, and each reported node is loaded and then
// emitted, waiting out any output stall. The input is not ready until the
// last beat of a report has gone. Reset clears the graph at once; no clearing
// pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rag_deadlock_detector_core_assert.svh"

module rag_deadlock_detector_core #(
	parameter int PROC_COUNT = rag_pkg::PROC_COUNT_DEF,
	parameter int LOCK_COUNT = rag_pkg::LOCK_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [1:0] action, [4:2] proc_id, [7:5] lock_id
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [2:0] node_id, [5:3] victim_pid,
	                                   // [8:6] victim_lock, rest zero
	output logic [1:0]  m_axis_tuser,  // [0] found, [1] node_is_lock
	output logic        m_axis_tlast
);
	import rag_pkg::*;

	localparam int NODE_COUNT = PROC_COUNT + LOCK_COUNT;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int IDX_W      = $clog2(NODE_COUNT + 1);
	localparam int LK_W       = $clog2(LOCK_COUNT + 1);
	localparam int CNT_W      = $clog2(OUT_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DFS,
		ST_WALK,
		ST_VICTIM,
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      root_q;
	logic [NODE_W-1:0]     sp_q;
	logic [NODE_W-1:0]     stk_node_q [NODE_COUNT];
	logic [IDX_W-1:0]      stk_idx_q  [NODE_COUNT];
	logic [NODE_COUNT-1:0] seen_q;
	logic [NODE_COUNT-1:0] onstk_q;
	logic [NODE_W-1:0]     hit_u_q;
	logic [NODE_W-1:0]     hit_w_q;
	logic [LK_W-1:0]       vk_q;
	logic [ID_W-1:0]       vp_q;
	logic [ID_W-1:0]       vl_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic                  out_found_q;
	logic                  out_lock_q;
	logic [ID_W-1:0]       out_id_q;
	logic [ID_W-1:0]       out_vp_q;
	logic [ID_W-1:0]       out_vl_q;
	logic                  out_last_q;

	rag_action_t           in_action;
	logic [ID_W-1:0]       in_pid;
	logic [ID_W-1:0]       in_lid;
	rag_upd_t              upd;
	logic [NODE_W-1:0]     top_node;
	logic [IDX_W-1:0]      top_idx;
	logic [NODE_W-1:0]     top_col;
	logic [NODE_W-1:0]     rd_row;
	logic [NODE_W-1:0]     rd_col;
	logic                  rd_bit;
	logic [NODE_W-1:0]     rep_node;
	logic                  rep_last;

	assign in_action = rag_action_t'(s_axis_tdata[1:0]);
	assign in_pid    = s_axis_tdata[4:2];
	assign in_lid    = s_axis_tdata[7:5];

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		upd.valid   = s_axis_tvalid && s_axis_tready && (in_action != ACT_DETECT) &&
		              (32'(in_pid) < PROC_COUNT) && (32'(in_lid) < LOCK_COUNT);
		upd.action  = in_action;
		upd.proc_id = in_pid;
		upd.lock_id = in_lid;
	end

	assign top_node = stk_node_q[sp_q];
	assign top_idx  = stk_idx_q[sp_q];
	assign top_col  = NODE_W'(top_idx);
	assign rd_row   = (state_q == ST_VICTIM) ? NODE_W'(vk_q) : top_node;
	assign rd_col   = (state_q == ST_VICTIM) ? hit_u_q : top_col;

	assign rep_node = stk_node_q[sp_q];
	assign rep_last = (sp_q == '0) || (cnt_q == CNT_W'(OUT_MAX - 1));

	rag_edge_mem #(
		.PROC_COUNT (PROC_COUNT),
		.LOCK_COUNT (LOCK_COUNT),
		.NODE_W     (NODE_W)
	) u_edge_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.rd_row (rd_row),
		.rd_col (rd_col),
		.rd_bit (rd_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_q      <= '0;
			sp_q        <= '0;
			seen_q      <= '0;
			onstk_q     <= '0;
			cnt_q       <= '0;
			vk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && in_action == ACT_DETECT) begin
						seen_q  <= '0;
						onstk_q <= '0;
						root_q  <= '0;
						sp_q    <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_q == IDX_W'(NODE_COUNT)) begin
						out_found_q <= 1'b0;
						out_lock_q  <= 1'b0;
						out_id_q    <= '0;
						out_vp_q    <= '0;
						out_vl_q    <= '0;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end else begin
						root_q <= root_q + 1'b1;
						if (!seen_q[NODE_W'(root_q)]) begin
							sp_q                       <= '0;
							stk_node_q[0]              <= NODE_W'(root_q);
							stk_idx_q[0]               <= '0;
							seen_q[NODE_W'(root_q)]    <= 1'b1;
							onstk_q[NODE_W'(root_q)]   <= 1'b1;
							state_q                    <= ST_DFS;
						end
					end
				end
				ST_DFS: begin
					if (top_idx == IDX_W'(NODE_COUNT)) begin
						onstk_q[top_node] <= 1'b0;
						if (sp_q == '0) begin
							state_q <= ST_ROOT;
						end else begin
							sp_q <= sp_q - 1'b1;
						end
					end else if (rd_bit && !seen_q[top_col]) begin
						stk_idx_q[sp_q]          <= top_idx + 1'b1;
						stk_node_q[sp_q + 1'b1]  <= top_col;
						stk_idx_q[sp_q + 1'b1]   <= '0;
						sp_q                     <= sp_q + 1'b1;
						seen_q[top_col]          <= 1'b1;
						onstk_q[top_col]         <= 1'b1;
					end else if (rd_bit && onstk_q[top_col]) begin
						// Back edge: restart the stack as the path search from its tail.
						hit_u_q         <= top_node;
						hit_w_q         <= top_col;
						onstk_q         <= {{(NODE_COUNT-1){1'b0}}, 1'b1} << top_node;
						sp_q            <= '0;
						stk_node_q[0]   <= top_node;
						stk_idx_q[0]    <= '0;
						state_q         <= ST_WALK;
					end else begin
						stk_idx_q[sp_q] <= top_idx + 1'b1;
					end
				end
				ST_WALK: begin
					if (top_idx == IDX_W'(NODE_COUNT)) begin
						onstk_q[top_node] <= 1'b0;
						if (sp_q == '0) begin
							state_q <= ST_ROOT;
							root_q  <= IDX_W'(NODE_COUNT);
						end else begin
							sp_q <= sp_q - 1'b1;
						end
					end else if (rd_bit && top_col == hit_u_q) begin
						cnt_q <= '0;
						if (32'(hit_u_q) < LOCK_COUNT) begin
							vl_q    <= ID_W'(hit_u_q);
							vp_q    <= (32'(hit_w_q) >= LOCK_COUNT) ?
							           ID_W'(hit_w_q - NODE_W'(LOCK_COUNT)) : '0;
							state_q <= ST_LOAD;
						end else begin
							vp_q    <= ID_W'(hit_u_q - NODE_W'(LOCK_COUNT));
							vl_q    <= '0;
							vk_q    <= '0;
							state_q <= ST_VICTIM;
						end
					end else if (rd_bit && !onstk_q[top_col]) begin
						stk_idx_q[sp_q]          <= top_idx + 1'b1;
						stk_node_q[sp_q + 1'b1]  <= top_col;
						stk_idx_q[sp_q + 1'b1]   <= '0;
						sp_q                     <= sp_q + 1'b1;
						onstk_q[top_col]         <= 1'b1;
					end else begin
						stk_idx_q[sp_q] <= top_idx + 1'b1;
					end
				end
				ST_VICTIM: begin
					// The highest lock holding the process wins, so later hits overwrite.
					if (vk_q == LK_W'(LOCK_COUNT)) begin
						state_q <= ST_LOAD;
					end else begin
						if (rd_bit) begin
							vl_q <= ID_W'(vk_q);
						end
						vk_q <= vk_q + 1'b1;
					end
				end
				ST_LOAD: begin
					out_found_q <= 1'b1;
					out_lock_q  <= (32'(rep_node) < LOCK_COUNT);
					out_id_q    <= (32'(rep_node) < LOCK_COUNT) ? ID_W'(rep_node) :
					               ID_W'(rep_node - NODE_W'(LOCK_COUNT));
					out_vp_q    <= rep_last ? vp_q : '0;
					out_vl_q    <= rep_last ? vl_q : '0;
					out_last_q  <= rep_last;
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							sp_q    <= sp_q - 1'b1;
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_vl_q, out_vp_q, out_id_q};
	assign m_axis_tuser  = {out_lock_q, out_found_q};
	assign m_axis_tlast  = out_last_q;

	`RAG_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid)
	`RAG_ASSERT_NOW(a_nocycle_single, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
	`RAG_ASSERT_NEXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast,
		s_axis_tready)
	`RAG_ASSERT_NOW(a_victim_last_only, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[8:3] == 6'd0)

endmodule

[design/rag_edge_mem.sv]
// ----------------------------------------------------------------------------
// rag_edge_mem
// Bit-matrix store of the graph: one row of outgoing edges per node, with
// locks numbered first and processes after them. One bit read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rag_edge_mem #(
	parameter int PROC_COUNT = rag_pkg::PROC_COUNT_DEF,
	parameter int LOCK_COUNT = rag_pkg::LOCK_COUNT_DEF,
	parameter int NODE_W     = $clog2(PROC_COUNT + LOCK_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rag_pkg::rag_upd_t upd,
	input  logic [NODE_W-1:0] rd_row,
	input  logic [NODE_W-1:0] rd_col,
	output logic              rd_bit
);
	import rag_pkg::*;

	localparam int NODE_COUNT = PROC_COUNT + LOCK_COUNT;

	logic [NODE_COUNT-1:0] rows_q [NODE_COUNT];
	logic [NODE_W-1:0]     pnode;
	logic [NODE_W-1:0]     lnode;

	assign pnode  = NODE_W'(LOCK_COUNT) + NODE_W'(upd.proc_id);
	assign lnode  = NODE_W'(upd.lock_id);
	assign rd_bit = rows_q[rd_row][rd_col];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				rows_q[i] <= '0;
			end
		end else if (upd.valid) begin
			case (upd.action)
				ACT_REQUEST: begin
					rows_q[pnode][lnode] <= 1'b1;
				end
				ACT_ALLOC: begin
					rows_q[lnode][pnode] <= 1'b1;
					rows_q[pnode][lnode] <= 1'b0;
				end
				ACT_DEALLOC: begin
					rows_q[lnode][pnode] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
